[rtl/rcfp_pkg.sv]
package rcfp_pkg;

    localparam int LEN_BITS_DEF   = 32;
    localparam int COUNT_BITS_DEF = 31;
    localparam int Q_DEPTH_LOG    = 2;

    typedef enum logic [3:0] {
        M_IDLE, M_ERROR, M_HDR, M_HDR_LF, M_ELEM, M_LEN, M_LEN_LF, M_BULK,
        M_BULK_CR, M_BULK_LF, M_SIMPLE, M_INT, M_NULL_CR, M_NULL_LF
    } mode_t;

    typedef enum logic [2:0] {
        K_PAYLOAD = 3'd0, K_STR_END = 3'd1, K_NULL = 3'd2, K_INT = 3'd3, K_ERROR = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        E_START = 3'd0, E_NUMBER = 3'd1, E_COUNT = 3'd2, E_LENGTH = 3'd3,
        E_TERM = 3'd4, E_NAME = 3'd5, E_ARGTYPE = 3'd6
    } err_t;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_USCR  = 8'h5F;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [63:0] I64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TWO63       = 64'h8000_0000_0000_0000;
    localparam logic [63:0] TENTH_LIMIT = 64'd922337203685477580;

    // one result word
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload;
        logic [30:0] element_index;
        logic [63:0] int_value;
        err_t        error_code;
        logic        frame_done;
        logic        last;
    } res_t;

    // front to back: up to two result words caused by one byte
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } pair_t;

endpackage

[rtl/rcfp_front.sv]
module rcfp_front #(
    parameter int LEN_BITS   = rcfp_pkg::LEN_BITS_DEF,
    parameter int COUNT_BITS = rcfp_pkg::COUNT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [7:0]           data_byte,
    input  logic                 restart,
    output rcfp_pkg::pair_t      pair
);
    import rcfp_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [30:0] left_reg, left_next;
    logic [30:0] pos_reg, pos_next;
    logic [LEN_BITS-1:0] bytes_reg, bytes_next;
    logic [63:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic        seen_reg, seen_next;
    logic        stop_reg, stop_next;
    logic        ovf_reg, ovf_next;
    logic        hcr_reg, hcr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            left_reg  <= '0;
            pos_reg   <= '0;
            bytes_reg <= '0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            stop_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            hcr_reg   <= 1'b0;
        end
        else if (in_valid)
        begin
            mode_reg  <= mode_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            bytes_reg <= bytes_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            seen_reg  <= seen_next;
            stop_reg  <= stop_next;
            ovf_reg   <= ovf_next;
            hcr_reg   <= hcr_next;
        end
    end

    // effective state after optional restart
    mode_t       m;
    logic [30:0] left_e, pos_e;
    logic [63:0] acc_e;
    logic        neg_e, seen_e, stop_e, ovf_e, hcr_e;
    logic        is_digit;
    logic [3:0]  dval;
    logic [63:0] acc_x10;
    logic        acc_big;
    logic [LEN_BITS-1:0] bytes_dec;
    logic        last_elem;
    res_t        rr [2];
    logic [1:0]  n;

    assign dval     = data_byte[3:0];
    assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    assign acc_x10  = (acc_e << 3) + (acc_e << 1) + {60'd0, dval};
    assign acc_big  = acc_e > TENTH_LIMIT;
    assign last_elem = left_e <= 31'd1;
    assign bytes_dec = bytes_reg - 1'b1;

    always_comb
    begin
        logic fin;
        kind_t fkind;
        logic [63:0] fival;
        logic err;
        err_t ecode;
        logic pay0;
        logic [7:0] pb0;
        logic pay1;
        logic content_c;

        m      = restart ? M_IDLE : mode_reg;
        left_e = restart ? '0 : left_reg;
        pos_e  = restart ? '0 : pos_reg;
        acc_e  = restart ? '0 : acc_reg;
        neg_e  = restart ? 1'b0 : neg_reg;
        seen_e = restart ? 1'b0 : seen_reg;
        stop_e = restart ? 1'b0 : stop_reg;
        ovf_e  = restart ? 1'b0 : ovf_reg;
        hcr_e  = restart ? 1'b0 : hcr_reg;

        mode_next  = m;
        left_next  = left_e;
        pos_next   = pos_e;
        bytes_next = restart ? '0 : bytes_reg;
        acc_next   = acc_e;
        neg_next   = neg_e;
        seen_next  = seen_e;
        stop_next  = stop_e;
        ovf_next   = ovf_e;
        hcr_next   = hcr_e;

        fin = 1'b0; fkind = K_STR_END; fival = '0;
        err = 1'b0; ecode = E_START;
        pay0 = 1'b0; pb0 = data_byte; pay1 = 1'b0;
        content_c = 1'b0;

        case (m)
            M_IDLE:
            begin
                pos_next = '0; left_next = '0;
                acc_next = '0; neg_next = 1'b0; seen_next = 1'b0;
                stop_next = 1'b0; ovf_next = 1'b0; hcr_next = 1'b0;
                if (data_byte == CH_STAR) mode_next = M_HDR;
                else begin err = 1'b1; ecode = E_START; end
            end
            M_HDR, M_LEN:
            begin
                if (is_digit)
                begin
                    if (acc_big || acc_x10 > I64_MAX) begin err = 1'b1; ecode = E_NUMBER; end
                    else begin acc_next = acc_x10; seen_next = 1'b1; end
                end
                else if (!seen_e)
                begin
                    if (data_byte == CH_MINUS && m == M_LEN && !neg_e) neg_next = 1'b1;
                    else begin err = 1'b1; ecode = E_NUMBER; end
                end
                else if (data_byte == CH_CR)
                    mode_next = (m == M_LEN) ? M_LEN_LF : M_HDR_LF;
                else begin err = 1'b1; ecode = E_NUMBER; end
            end
            M_HDR_LF:
            begin
                if (data_byte != CH_LF) begin err = 1'b1; ecode = E_TERM; end
                else if (acc_e == '0 || acc_e > 64'((64'd1 << COUNT_BITS) - 1))
                begin err = 1'b1; ecode = E_COUNT; end
                else
                begin
                    left_next = acc_e[30:0];
                    pos_next = '0;
                    acc_next = '0; neg_next = 1'b0; seen_next = 1'b0;
                    stop_next = 1'b0; ovf_next = 1'b0; hcr_next = 1'b0;
                    mode_next = M_ELEM;
                end
            end
            M_ELEM:
            begin
                acc_next = '0; neg_next = 1'b0; seen_next = 1'b0;
                stop_next = 1'b0; ovf_next = 1'b0; hcr_next = 1'b0;
                if (data_byte == CH_DOLL) mode_next = M_LEN;
                else if (pos_e == '0) begin err = 1'b1; ecode = E_NAME; end
                else
                begin
                    case (data_byte)
                        CH_PLUS:  mode_next = M_SIMPLE;
                        CH_COLON: mode_next = M_INT;
                        CH_USCR:  mode_next = M_NULL_CR;
                        CH_MINUS, CH_HASH, CH_COMMA, CH_STAR:
                            begin err = 1'b1; ecode = E_ARGTYPE; end
                        default: begin err = 1'b1; ecode = E_START; end
                    endcase
                end
            end
            M_LEN_LF:
            begin
                if (data_byte != CH_LF) begin err = 1'b1; ecode = E_TERM; end
                else if (neg_e && acc_e == 64'd1)
                begin
                    if (pos_e == '0) begin err = 1'b1; ecode = E_NAME; end
                    else begin fin = 1'b1; fkind = K_NULL; end
                end
                else if ((neg_e && acc_e != '0) ||
                         acc_e > 64'((65'd1 << LEN_BITS) - 1))
                begin err = 1'b1; ecode = E_LENGTH; end
                else
                begin
                    bytes_next = acc_e[LEN_BITS-1:0];
                    mode_next = (acc_e == '0) ? M_BULK_CR : M_BULK;
                end
            end
            M_BULK:
            begin
                pay0 = 1'b1;
                bytes_next = bytes_dec;
                if (bytes_dec == '0) mode_next = M_BULK_CR;
            end
            M_BULK_CR:
                if (data_byte == CH_CR) mode_next = M_BULK_LF;
                else begin err = 1'b1; ecode = E_TERM; end
            M_BULK_LF:
                if (data_byte == CH_LF) begin fin = 1'b1; fkind = K_STR_END; end
                else begin err = 1'b1; ecode = E_TERM; end
            M_NULL_CR:
                if (data_byte == CH_CR) mode_next = M_NULL_LF;
                else begin err = 1'b1; ecode = E_TERM; end
            M_NULL_LF:
                if (data_byte == CH_LF) begin fin = 1'b1; fkind = K_NULL; end
                else begin err = 1'b1; ecode = E_TERM; end
            M_SIMPLE:
            begin
                if (hcr_e)
                begin
                    if (data_byte == CH_LF)
                    begin
                        hcr_next = 1'b0; fin = 1'b1; fkind = K_STR_END;
                    end
                    else
                    begin
                        pay0 = 1'b1; pb0 = CH_CR;
                        if (data_byte != CH_CR) begin hcr_next = 1'b0; pay1 = 1'b1; end
                    end
                end
                else if (data_byte == CH_CR) hcr_next = 1'b1;
                else pay0 = 1'b1;
            end
            M_INT:
            begin
                if (hcr_e && data_byte == CH_LF)
                begin
                    hcr_next = 1'b0;
                    if (!seen_e || ovf_e || (!neg_e && acc_e > I64_MAX))
                    begin err = 1'b1; ecode = E_NUMBER; end
                    else
                    begin
                        fin = 1'b1; fkind = K_INT;
                        fival = neg_e ? (64'd0 - acc_e) : acc_e;
                    end
                end
                else if (hcr_e)
                begin
                    // held CR is line content and stops the digits
                    stop_next = 1'b1;
                    if (data_byte != CH_CR) hcr_next = 1'b0;
                end
                else if (data_byte == CH_CR) hcr_next = 1'b1;
                else content_c = 1'b1;
            end
            default: ;
        endcase

        if (content_c && !stop_e)
        begin
            if (is_digit)
            begin
                seen_next = 1'b1;
                if (!ovf_e)
                begin
                    if (acc_big || acc_x10 > TWO63) ovf_next = 1'b1;
                    else acc_next = acc_x10;
                end
            end
            else if (data_byte == CH_MINUS && !seen_e && !neg_e) neg_next = 1'b1;
            else stop_next = 1'b1;
        end

        if (fin)
        begin
            pos_next  = pos_e + 31'd1;
            left_next = last_elem ? '0 : left_e - 31'd1;
            mode_next = last_elem ? M_IDLE : M_ELEM;
            acc_next = '0; neg_next = 1'b0; seen_next = 1'b0;
            stop_next = 1'b0; ovf_next = 1'b0; hcr_next = 1'b0;
        end
        if (err) mode_next = M_ERROR;

        rr[0] = '0; rr[1] = '0;
        // idle clears the position before anything is reported
        rr[0].element_index = (m == M_IDLE) ? 31'd0 : pos_e;
        rr[1].element_index = (m == M_IDLE) ? 31'd0 : pos_e;
        n = 2'd0;
        if (err)
        begin
            rr[0].kind = K_ERROR; rr[0].error_code = ecode; n = 2'd1;
        end
        else if (fin)
        begin
            rr[0].kind = fkind; rr[0].int_value = fival;
            rr[0].frame_done = last_elem; n = 2'd1;
        end
        else if (pay0)
        begin
            rr[0].kind = K_PAYLOAD; rr[0].payload = pb0; n = 2'd1;
            if (pay1)
            begin
                rr[1].kind = K_PAYLOAD; rr[1].payload = data_byte; n = 2'd2;
            end
        end
        rr[0].last = (n == 2'd1);
        rr[1].last = 1'b1;

        pair.cnt = in_valid ? n : 2'd0;
        pair.r0  = rr[0];
        pair.r1  = rr[1];
    end

    property p_err_single;
        @(posedge clk) disable iff (!rst_n)
        (pair.cnt != 2'd0 && pair.r0.kind == K_ERROR) |-> pair.cnt == 2'd1;
    endproperty
    a_err_single: assert property (p_err_single) else $error("error word not alone");

    property p_err_sticky;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !restart && mode_reg == M_ERROR) |-> pair.cnt == 2'd0;
    endproperty
    a_err_sticky: assert property (p_err_sticky) else $error("output while in error");

    property p_pair_payload;
        @(posedge clk) disable iff (!rst_n)
        (pair.cnt == 2'd2) |-> (pair.r0.kind == K_PAYLOAD && pair.r1.kind == K_PAYLOAD);
    endproperty
    a_pair_payload: assert property (p_pair_payload) else $error("bad double word");

endmodule

[rtl/rcfp_queue.sv]
module rcfp_queue #(
    parameter int DEPTH_LOG = rcfp_pkg::Q_DEPTH_LOG
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rcfp_pkg::pair_t   pair,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output rcfp_pkg::res_t    head
);
    import rcfp_pkg::*;

    localparam int DEPTH = 1 << DEPTH_LOG;

    res_t mem [DEPTH];
    logic [DEPTH_LOG-1:0] wr_reg, rd_reg;
    logic [DEPTH_LOG:0]   cnt_reg, cnt_next;
    logic do_pop;

    assign empty  = (cnt_reg == '0);
    assign do_pop = pop && !empty;
    // room for two words guaranteed before taking a byte
    assign full   = cnt_reg > (DEPTH_LOG + 1)'(DEPTH - 2);
    assign head   = mem[rd_reg];
    assign cnt_next = cnt_reg + (DEPTH_LOG + 1)'(pair.cnt) - (DEPTH_LOG + 1)'(do_pop);

    always_ff @(posedge clk)
    begin
        if (pair.cnt != 2'd0) mem[wr_reg] <= pair.r0;
        if (pair.cnt == 2'd2) mem[wr_reg + 1'b1] <= pair.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + DEPTH_LOG'(pair.cnt);
            rd_reg  <= rd_reg + DEPTH_LOG'(do_pop);
            cnt_reg <= cnt_next;
        end
    end

    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (DEPTH_LOG + 1)'(DEPTH)) else $error("queue overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> pair.cnt == 2'd0) else $error("write while full");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (pair.cnt == 2'd0 && !do_pop) |=> $stable(cnt_reg)) else $error("count drift");

endmodule

[rtl/resp_command_frame_parser.sv]
// RESP command frame parser.
// Input side is a queue: drive data_byte/restart with push; a word is taken on
// a clock edge with push high and full low. One stream byte per word.
// Output side is a queue: while empty is low the oldest result word is on
// kind/payload/element_index/int_value/error_code/frame_done/last, and pop
// with empty low takes it.
// A byte yields zero, one or two result words; last marks the final word of
// a byte. A byte's words enter the queue on the edge that takes it and are
// visible right after that edge. Throughput is one byte per cycle while
// bytes yield at most one word each and pop keeps pace; a byte with two
// words needs two pops, so such bytes slow the input to the reader's pace.
// full rises while three or more of the four queue words wait.
// When pop is held low the queue fills and full rises, stalling the sender
// with no data lost.
// Reset (rst_n low, asynchronous) empties the queue and returns the parser
// to waiting for a '*' header. After an error word the parser gives nothing
// until a byte with restart set.
module resp_command_frame_parser #(
    parameter int LEN_BITS   = rcfp_pkg::LEN_BITS_DEF,
    parameter int COUNT_BITS = rcfp_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  kind,
    output logic [7:0]  payload,
    output logic [30:0] element_index,
    output logic signed [63:0] int_value,
    output logic [2:0]  error_code,
    output logic        frame_done,
    output logic        last
);
    import rcfp_pkg::*;

    pair_t pair;
    res_t  head;
    logic  take;

    assign take = push && !full;

    rcfp_front #(.LEN_BITS(LEN_BITS), .COUNT_BITS(COUNT_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(take),
        .data_byte(data_byte), .restart(restart), .pair(pair)
    );

    rcfp_queue #(.DEPTH_LOG(Q_DEPTH_LOG)) u_queue (
        .clk(clk), .rst_n(rst_n), .pair(pair), .full(full),
        .empty(empty), .pop(pop), .head(head)
    );

    assign kind          = head.kind;
    assign payload       = head.payload;
    assign element_index = head.element_index;
    assign int_value     = head.int_value;
    assign error_code    = head.error_code;
    assign frame_done    = head.frame_done;
    assign last          = head.last;

endmodule

[test/resp_command_frame_parser_tb.sv]
`timescale 1ns / 100ps

module resp_command_frame_parser_tb;
    import rcfp_pkg::*;

    typedef struct {
        logic [7:0] b;
        logic       rs;
        bit         typed;
        kind_t      k;
        err_t       e;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        restart = 1'b0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [2:0]  kind;
    logic [7:0]  payload;
    logic [30:0] element_index;
    logic signed [63:0] int_value;
    logic [2:0]  error_code;
    logic        frame_done;
    logic        last;

    resp_command_frame_parser dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .data_byte(data_byte),
        .restart(restart), .empty(empty), .pop(pop), .kind(kind), .payload(payload),
        .element_index(element_index), .int_value(int_value), .error_code(error_code),
        .frame_done(frame_done), .last(last)
    );

    stim_t stim_q[$];
    res_t  byte_out[$];
    res_t  want_q[$];
    int    errs = 0;
    int    sent = 0;
    int    dir_n = 0;
    bit    hold = 1'b0;

    // parser shadow state
    mode_t       pm = M_IDLE;
    logic [31:0] elem_left = 0;
    logic [30:0] elem_pos = 0;
    logic [63:0] bytes_left = 0;
    logic [63:0] acc = 0;
    logic        neg = 0, seen = 0, stopped = 0, ovf = 0, hcr = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("[resp_command_frame_parser] ERROR");
        $finish;
    end

    task emit(kind_t k, logic [7:0] p, logic [63:0] iv, err_t e, logic d);
        res_t r;
        r.kind = k;
        r.payload = p;
        r.element_index = elem_pos;
        r.int_value = iv;
        r.error_code = e;
        r.frame_done = d;
        r.last = 1'b0;
        byte_out.insert(byte_out.size(), r);
    endtask

    task clr_num();
        acc = 0;
        neg = 0;
        seen = 0;
        stopped = 0;
        ovf = 0;
        hcr = 0;
    endtask

    task raise(err_t e);
        emit(K_ERROR, 8'h00, 64'd0, e, 1'b0);
        pm = M_ERROR;
    endtask

    task close_elem(kind_t k, logic [63:0] iv);
        logic d;
        d = (elem_left <= 1);
        emit(k, 8'h00, iv, E_START, d);
        elem_pos = elem_pos + 1;
        elem_left = d ? 32'd0 : elem_left - 1;
        pm = d ? M_IDLE : M_ELEM;
        clr_num();
    endtask

    task len_digit(logic [7:0] c, bit sgn);
        logic [63:0] v;
        if (c >= "0" && c <= "9")
        begin
            if (acc > TENTH_LIMIT)
                raise(E_NUMBER);
            else
            begin
                v = acc * 10 + (c - "0");
                if (v > I64_MAX)
                    raise(E_NUMBER);
                else
                begin
                    acc = v;
                    seen = 1;
                end
            end
        end
        else if (!seen)
        begin
            if (c == CH_MINUS && sgn && !neg)
                neg = 1;
            else
                raise(E_NUMBER);
        end
        else if (c == CH_CR)
            pm = sgn ? M_LEN_LF : M_HDR_LF;
        else
            raise(E_NUMBER);
    endtask

    task line_byte(logic [7:0] c);
        logic [63:0] v;
        if (pm == M_SIMPLE)
            emit(K_PAYLOAD, c, 64'd0, E_START, 1'b0);
        else if (!stopped)
        begin
            if (c >= "0" && c <= "9")
            begin
                seen = 1;
                if (!ovf)
                begin
                    if (acc > TENTH_LIMIT)
                        ovf = 1;
                    else
                    begin
                        v = acc * 10 + (c - "0");
                        if (v > TWO63)
                            ovf = 1;
                        else
                            acc = v;
                    end
                end
            end
            else if (c == CH_MINUS && !seen && !neg)
                neg = 1;
            else
                stopped = 1;
        end
    endtask

    task line_close();
        if (pm == M_SIMPLE)
            close_elem(K_STR_END, 64'd0);
        else if (!seen || ovf || (!neg && acc > I64_MAX))
            raise(E_NUMBER);
        else
            close_elem(K_INT, neg ? -acc : acc);
    endtask

    task elem_begin(logic [7:0] c);
        clr_num();
        if (c == CH_DOLL)
            pm = M_LEN;
        else if (elem_pos == 0)
            raise(E_NAME);
        else if (c == CH_PLUS)
            pm = M_SIMPLE;
        else if (c == CH_COLON)
            pm = M_INT;
        else if (c == CH_USCR)
            pm = M_NULL_CR;
        else if (c == CH_MINUS || c == CH_HASH || c == CH_COMMA || c == CH_STAR)
            raise(E_ARGTYPE);
        else
            raise(E_START);
    endtask

    task len_close();
        if (neg && acc == 1)
        begin
            if (elem_pos == 0)
                raise(E_NAME);
            else
                close_elem(K_NULL, 64'd0);
        end
        else if ((neg && acc != 0) || acc > 64'hFFFF_FFFF)
            raise(E_LENGTH);
        else
        begin
            bytes_left = acc;
            pm = (acc == 0) ? M_BULK_CR : M_BULK;
        end
    endtask

    task parse_byte(logic [7:0] c, logic rs);
        byte_out.delete();
        if (rs)
        begin
            pm = M_IDLE;
            elem_left = 0;
            elem_pos = 0;
            bytes_left = 0;
            clr_num();
        end
        case (pm)
            M_IDLE:
            begin
                elem_pos = 0;
                elem_left = 0;
                clr_num();
                if (c == CH_STAR)
                    pm = M_HDR;
                else
                    raise(E_START);
            end
            M_HDR: len_digit(c, 0);
            M_HDR_LF:
            begin
                if (c != CH_LF)
                    raise(E_TERM);
                else if (acc == 0 || acc > 64'h7FFF_FFFF)
                    raise(E_COUNT);
                else
                begin
                    elem_left = acc[31:0];
                    elem_pos = 0;
                    clr_num();
                    pm = M_ELEM;
                end
            end
            M_ELEM: elem_begin(c);
            M_LEN: len_digit(c, 1);
            M_LEN_LF:
            begin
                if (c != CH_LF)
                    raise(E_TERM);
                else
                    len_close();
            end
            M_BULK:
            begin
                emit(K_PAYLOAD, c, 64'd0, E_START, 1'b0);
                bytes_left = bytes_left - 1;
                if (bytes_left == 0)
                    pm = M_BULK_CR;
            end
            M_BULK_CR:
            begin
                if (c == CH_CR)
                    pm = M_BULK_LF;
                else
                    raise(E_TERM);
            end
            M_BULK_LF:
            begin
                if (c == CH_LF)
                    close_elem(K_STR_END, 64'd0);
                else
                    raise(E_TERM);
            end
            M_SIMPLE, M_INT:
            begin
                if (hcr)
                begin
                    if (c == CH_LF)
                    begin
                        hcr = 0;
                        line_close();
                    end
                    else
                    begin
                        line_byte(CH_CR);
                        if (c != CH_CR)
                        begin
                            hcr = 0;
                            line_byte(c);
                        end
                    end
                end
                else if (c == CH_CR)
                    hcr = 1;
                else
                    line_byte(c);
            end
            M_NULL_CR:
            begin
                if (c == CH_CR)
                    pm = M_NULL_LF;
                else
                    raise(E_TERM);
            end
            M_NULL_LF:
            begin
                if (c == CH_LF)
                    close_elem(K_NULL, 64'd0);
                else
                    raise(E_TERM);
            end
            default: ;
        endcase
        if (byte_out.size() > 0)
            byte_out[byte_out.size() - 1].last = 1'b1;
    endtask

    task add(logic [7:0] b, logic rs);
        stim_t s;
        s.b = b;
        s.rs = rs;
        s.typed = 0;
        s.k = K_PAYLOAD;
        s.e = E_START;
        stim_q.insert(stim_q.size(), s);
    endtask

    task add_err(logic [7:0] b, logic rs, err_t e);
        add(b, rs);
        stim_q[stim_q.size() - 1].typed = 1;
        stim_q[stim_q.size() - 1].k = K_ERROR;
        stim_q[stim_q.size() - 1].e = e;
    endtask

    task add_str(string s);
        for (int i = 0; i < s.len(); i++)
            add(s[i], 1'b0);
    endtask

    task add_rand_bytes(int n, bit cr_ok);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            b = $urandom_range(0, 255);
            if (b == CH_CR && !cr_ok)
                b = 8'h41;
            add(b, 1'b0);
        end
    endtask

    task gen_frame();
        int n, t, len, start;
        logic [63:0] v;
        start = stim_q.size();
        n = $urandom_range(1, 4);
        add(CH_STAR, $urandom_range(0, 9) != 0);
        case ($urandom_range(0, 19))
            0: add_str("0\r\n");
            1: add_str("2147483648\r\n");
            2: add_str("99999999999999999999\r\n");
            default: add_str($sformatf("%0d\r\n", n));
        endcase
        len = $urandom_range(0, 5);
        add_str($sformatf("$%0d\r\n", len));
        add_rand_bytes(len, 1);
        add_str("\r\n");
        for (int i = 1; i < n; i++)
        begin
            t = $urandom_range(0, 9);
            case (t)
                0, 1:
                begin
                    len = $urandom_range(0, 6);
                    if ($urandom_range(0, 9) == 0)
                        add_str("$-0\r\n");
                    else
                        add_str($sformatf("$%0d\r\n", len));
                    add_rand_bytes(len, 1);
                    add_str("\r\n");
                end
                2: add_str("$-1\r\n");
                3: add_str("_\r\n");
                4, 5:
                begin
                    add(CH_PLUS, 1'b0);
                    add_rand_bytes($urandom_range(0, 4), 0);
                    case ($urandom_range(0, 3))
                        0: add_str("\rZ");
                        1: add_str("\r\r");
                        default: ;
                    endcase
                    add_str("\r\n");
                end
                6, 7:
                begin
                    add(CH_COLON, 1'b0);
                    v = {$urandom, $urandom};
                    case ($urandom_range(0, 7))
                        0: add_str("9223372036854775808");
                        1: add_str("-9223372036854775808");
                        2: add_str("-9223372036854775809");
                        3: add_str($sformatf("%0d", $urandom_range(0, 999)));
                        4: add_str("x");
                        default: add_str($sformatf("%0d", $signed(v)));
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        add_str("7a-9");
                    add_str("\r\n");
                end
                8:
                begin
                    case ($urandom_range(0, 5))
                        0: add_str("-ERR\r\n");
                        1: add_str("#t\r\n");
                        2: add_str(",1.5\r\n");
                        3: add_str("*1\r\n");
                        4: add_str("$4294967296\r\n");
                        default: add_rand_bytes(1, 1);
                    endcase
                end
                default:
                begin
                    add_str("$4294967295\r\n");
                    n = i + 1;
                end
            endcase
        end
        if ($urandom_range(0, 7) == 0)
        begin
            t = $urandom_range(start, stim_q.size() - 1);
            stim_q[t].b = $urandom_range(0, 255);
            stim_q[t].rs = $urandom_range(0, 1);
        end
    endtask

    // response side: the pop mode is redrawn at random at regular intervals
    int rcnt = 0;
    int rmode = 0;
    always @(posedge clk)
    begin
        rcnt <= rcnt + 1;
        if (rcnt % 50 == 0)
            rmode <= $urandom_range(0, 3);
        if (hold)
            pop <= 1'b0;
        else
            case (rmode)
                0: pop <= 1'b1;
                1: pop <= $urandom_range(0, 1);
                2: pop <= ($urandom_range(0, 9) == 0);
                default: pop <= ($urandom_range(0, 3) != 0);
            endcase
    end

    initial
    begin
        wait (sent >= 600);
        hold = 1'b1;
        repeat (300) @(posedge clk);
        hold = 1'b0;
    end

    int mi = 0;
    always @(posedge clk)
    begin
        res_t w;
        if (rst_n && pop && !empty)
        begin
            if (want_q.size() == 0)
            begin
                $display("%0t: unexpected word exp none got kind %0d", $time, kind);
                errs++;
            end
            else
            begin
                w = want_q.pop_front();
                if (kind !== w.kind)
                    begin $display("%0t: kind exp %0d got %0d", $time, w.kind, kind); errs++; end
                if (payload !== w.payload)
                    begin $display("%0t: payload exp %h got %h", $time, w.payload, payload);
                    errs++; end
                if (element_index !== w.element_index)
                    begin $display("%0t: index exp %0d got %0d", $time, w.element_index,
                    element_index); errs++; end
                if (int_value !== w.int_value)
                    begin $display("%0t: int exp %0d got %0d", $time, $signed(w.int_value),
                    int_value); errs++; end
                if (error_code !== w.error_code)
                    begin $display("%0t: code exp %0d got %0d", $time, w.error_code,
                    error_code); errs++; end
                if (frame_done !== w.frame_done)
                    begin $display("%0t: done exp %b got %b", $time, w.frame_done,
                    frame_done); errs++; end
                if (last !== w.last)
                    begin $display("%0t: last exp %b got %b", $time, w.last, last); errs++; end
            end
        end
        if (rst_n && push && !full)
        begin
            parse_byte(data_byte, restart);
            if (stim_q[mi].typed)
            begin
                w.kind = stim_q[mi].k;
                w.payload = 0;
                w.element_index = 0;
                w.int_value = 0;
                w.error_code = stim_q[mi].e;
                w.frame_done = 0;
                w.last = 1;
                want_q.insert(want_q.size(), w);
            end
            else
                foreach (byte_out[i])
                    want_q.insert(want_q.size(), byte_out[i]);
            mi++;
        end
    end

    initial
    begin
        int di, burst;
        add_err(8'h41, 1'b0, E_START);
        add(CH_STAR, 1'b1); add_str("1\r\n"); add_err(CH_PLUS, 1'b0, E_NAME);
        add(CH_STAR, 1'b1); add_str("0\r"); add_err(CH_LF, 1'b0, E_COUNT);
        add(CH_STAR, 1'b1); add_str("2\r\n$1\r\n"); add(8'h00, 1'b0); add_str("\r\n");
        add_str(":7\r\n");
        dir_n = stim_q.size();
        while (stim_q.size() < dir_n + 1200)
            gen_frame();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        di = 0;
        while (di < stim_q.size())
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && di < stim_q.size())
            begin
                push <= 1'b1;
                data_byte <= stim_q[di].b;
                restart <= stim_q[di].rs;
                @(posedge clk);
                while (full)
                    @(posedge clk);
                di++;
                sent = di;
                burst--;
                if (di == dir_n || di == stim_q.size() / 2)
                begin
                    push <= 1'b0;
                    @(posedge clk);
                    while (want_q.size() != 0)
                        @(posedge clk);
                end
            end
            if ($urandom_range(0, 3) != 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        push <= 1'b0;
        @(posedge clk);
        while (want_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errs == 0)
            $display("[resp_command_frame_parser] OK");
        else
            $display("[resp_command_frame_parser] ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/rcfp_pkg.sv
rtl/rcfp_front.sv
rtl/rcfp_queue.sv
rtl/resp_command_frame_parser.sv
test/resp_command_frame_parser_tb.sv
